FILE: design/ptb_pkg.sv
package ptb_pkg;

    localparam int ID_W = 16;
    localparam int PING_W = 16;

    // Defaults for the top-level parameters.
    localparam int MAX_BEST_DEF = 6;
    localparam int REMOTE_DEPTH_DEF = 64;
    localparam int LOCAL_DEPTH_DEF = 16;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_BEST = 2'd3;

    // Status codes on the output channel.
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DUP = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // Job kinds decided by the front end.
    localparam logic [2:0] K_LADD = 3'd0;
    localparam logic [2:0] K_LREM = 3'd1;
    localparam logic [2:0] K_LNOP = 3'd2;
    localparam logic [2:0] K_RADD = 3'd3;
    localparam logic [2:0] K_RREM = 3'd4;
    localparam logic [2:0] K_RUPD = 3'd5;
    localparam logic [2:0] K_BEST = 3'd6;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ID_W-1:0]   id;
        logic [PING_W-1:0] key;
        logic [PING_W-1:0] ping;
    } job_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PING_W-1:0] ping;
    } rent_t;

endpackage

FILE: design/ptb_ram.sv
module ptb_ram #(
    parameter int W = 32,
    parameter int D = 64,
    localparam int AW = $clog2(D)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [D];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/ptb_front.sv
module ptb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           cmd,
    input  logic [15:0]          peer_id,
    input  logic                 is_local,
    input  logic [15:0]          ping,
    input  logic [15:0]          old_ping,
    output logic                 q_valid,
    output ptb_pkg::job_t        q_job,
    input  logic                 q_pop
);
    import ptb_pkg::*;

    job_t       slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    job_t       job_in;
    logic       push;

    // Classify the incoming beat into a job for the back end.
    always_comb
    begin
        job_in.id = peer_id;
        job_in.ping = ping;
        job_in.key = ping;
        case (cmd)
            CMD_ADD:    job_in.kind = is_local ? K_LADD : K_RADD;
            CMD_REMOVE: job_in.kind = is_local ? K_LREM : K_RREM;
            CMD_UPDATE:
            begin
                job_in.kind = is_local ? K_LNOP : K_RUPD;
                job_in.key = old_ping;
            end
            default:    job_in.kind = K_BEST;
        endcase
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_job = slot_reg[rptr_reg];

    // Two-entry queue pointers.
    always_comb
    begin
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = q_pop ? !rptr_reg : rptr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= job_in;
        end
    end

endmodule

FILE: design/ptb_back.sv
module ptb_back #(
    parameter int MAX_BEST = ptb_pkg::MAX_BEST_DEF,
    parameter int REMOTE_DEPTH = ptb_pkg::REMOTE_DEPTH_DEF,
    parameter int LOCAL_DEPTH = ptb_pkg::LOCAL_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  ptb_pkg::job_t        q_job,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [15:0]          best_peer_id,
    output logic                 found,
    output logic                 last
);
    import ptb_pkg::*;

    localparam int RAW = $clog2(REMOTE_DEPTH);
    localparam int RIW = $clog2(REMOTE_DEPTH + 1);
    localparam int LAW = $clog2(LOCAL_DEPTH);
    localparam int LIW = $clog2(LOCAL_DEPTH + 1);
    localparam int NW = $clog2(MAX_BEST + 1);
    localparam int RW = ID_W + PING_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FRD = 4'd1;
    localparam logic [3:0] S_FCHK = 4'd2;
    localparam logic [3:0] S_DRD = 4'd3;
    localparam logic [3:0] S_DWR = 4'd4;
    localparam logic [3:0] S_IRD = 4'd5;
    localparam logic [3:0] S_IWR = 4'd6;
    localparam logic [3:0] S_BRD = 4'd7;
    localparam logic [3:0] S_BCHK = 4'd8;
    localparam logic [3:0] S_BLOC = 4'd9;
    localparam logic [3:0] S_BFIN = 4'd10;
    localparam logic [3:0] S_RES = 4'd11;

    logic [3:0]      state_reg, state_next;
    job_t            job_reg, job_next;
    logic [RIW-1:0]  idx_reg, idx_next;
    logic [RIW-1:0]  rcount_reg, rcount_next;
    logic [LIW-1:0]  lidx_reg, lidx_next;
    logic [LIW-1:0]  lcount_reg, lcount_next;
    logic [ID_W-1:0] lid_reg [LOCAL_DEPTH];
    logic [ID_W-1:0] lid_next [LOCAL_DEPTH];
    logic [NW-1:0]   n_reg, n_next;
    logic            pv_reg, pv_next;
    logic [ID_W-1:0] pid_reg, pid_next;
    logic [1:0]      st_reg, st_next;
    logic            ov_reg;
    logic [1:0]      ost_reg;
    logic [ID_W-1:0] oid_reg;
    logic            ofound_reg, olast_reg;

    logic            we;
    logic [RAW-1:0]  waddr, raddr;
    logic [RW-1:0]   wdata, rdata;
    rent_t           rd_ent;
    logic            can_emit;
    logic            emit_v, e_found, e_last;
    logic [1:0]      e_status;
    logic [ID_W-1:0] e_id;
    logic            lhit;
    logic [LAW-1:0]  lpos;
    logic [ID_W-1:0] lcand;
    logic            cand;
    logic            n_full;

    ptb_ram #(
        .W (RW),
        .D (REMOTE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_ent = rdata;
    assign can_emit = !ov_reg || !out_stall;
    assign n_full = (n_reg == NW'(MAX_BEST));
    assign lcand = lid_reg[lidx_reg[LAW-1:0]];

    // First local entry that matches the queued id.
    always_comb
    begin
        lhit = 1'b0;
        lpos = '0;
        for (int i = LOCAL_DEPTH - 1; i >= 0; i--)
        begin
            if (LIW'(i) < lcount_reg && lid_reg[i] == q_job.id)
            begin
                lhit = 1'b1;
                lpos = LAW'(i);
            end
        end
    end

    // Read address follows the step of the shift or scan in progress.
    always_comb
    begin
        case (state_reg)
            S_DRD, S_DWR: raddr = RAW'(idx_reg + RIW'(1));
            S_IRD, S_IWR: raddr = RAW'(idx_reg - RIW'(1));
            default:      raddr = idx_reg[RAW-1:0];
        endcase
    end

    // Sequencer for one job.
    always_comb
    begin
        state_next = state_reg;
        job_next = job_reg;
        idx_next = idx_reg;
        rcount_next = rcount_reg;
        lidx_next = lidx_reg;
        lcount_next = lcount_reg;
        lid_next = lid_reg;
        n_next = n_reg;
        pv_next = pv_reg;
        pid_next = pid_reg;
        st_next = st_reg;
        we = 1'b0;
        waddr = idx_reg[RAW-1:0];
        wdata = rdata;
        q_pop = 1'b0;
        emit_v = 1'b0;
        e_status = ST_OK;
        e_id = '0;
        e_found = 1'b0;
        e_last = 1'b1;
        cand = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    job_next = q_job;
                    idx_next = '0;
                    n_next = '0;
                    pv_next = 1'b0;
                    st_next = ST_OK;
                    state_next = S_RES;
                    case (q_job.kind)
                        K_LADD:
                        begin
                            if (lhit)
                            begin
                                st_next = ST_DUP;
                            end
                            else if (lcount_reg == LIW'(LOCAL_DEPTH))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                lid_next[0] = q_job.id;
                                for (int i = 1; i < LOCAL_DEPTH; i++)
                                begin
                                    lid_next[i] = lid_reg[i-1];
                                end
                                lcount_next = lcount_reg + LIW'(1);
                            end
                        end
                        K_LREM:
                        begin
                            if (!lhit)
                            begin
                                st_next = ST_MISSING;
                            end
                            else
                            begin
                                for (int i = 0; i < LOCAL_DEPTH - 1; i++)
                                begin
                                    if (LAW'(i) >= lpos)
                                    begin
                                        lid_next[i] = lid_reg[i+1];
                                    end
                                end
                                lcount_next = lcount_reg - LIW'(1);
                            end
                        end
                        K_RADD, K_RREM, K_RUPD: state_next = S_FRD;
                        K_BEST:                 state_next = S_BRD;
                        default:                state_next = S_RES;
                    endcase
                end
            end
            // Search the remote table for id at the key ping.
            S_FRD:
            begin
                if (idx_reg >= rcount_reg)
                begin
                    if (job_reg.kind == K_RADD)
                    begin
                        if (rcount_reg == RIW'(REMOTE_DEPTH))
                        begin
                            st_next = ST_FULL;
                            state_next = S_RES;
                        end
                        else
                        begin
                            idx_next = rcount_reg;
                            state_next = S_IRD;
                        end
                    end
                    else
                    begin
                        st_next = ST_MISSING;
                        state_next = S_RES;
                    end
                end
                else
                begin
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (rd_ent.id == job_reg.id && rd_ent.ping == job_reg.key)
                begin
                    if (job_reg.kind == K_RADD)
                    begin
                        st_next = ST_DUP;
                        state_next = S_RES;
                    end
                    else
                    begin
                        state_next = S_DRD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + RIW'(1);
                    state_next = S_FRD;
                end
            end
            // Close the gap at idx by moving later entries down one.
            S_DRD:
            begin
                if ({1'b0, idx_reg} + (RIW+1)'(1) >= {1'b0, rcount_reg})
                begin
                    rcount_next = rcount_reg - RIW'(1);
                    if (job_reg.kind == K_RUPD)
                    begin
                        idx_next = rcount_reg - RIW'(1);
                        state_next = S_IRD;
                    end
                    else
                    begin
                        state_next = S_RES;
                    end
                end
                else
                begin
                    state_next = S_DWR;
                end
            end
            S_DWR:
            begin
                we = 1'b1;
                idx_next = idx_reg + RIW'(1);
                state_next = S_DRD;
            end
            // Insert from the end, moving larger pings up one.
            S_IRD:
            begin
                if (idx_reg == '0)
                begin
                    we = 1'b1;
                    wdata = {job_reg.id, job_reg.ping};
                    rcount_next = rcount_reg + RIW'(1);
                    state_next = S_RES;
                end
                else
                begin
                    state_next = S_IWR;
                end
            end
            S_IWR:
            begin
                we = 1'b1;
                if (rd_ent.ping > job_reg.ping)
                begin
                    idx_next = idx_reg - RIW'(1);
                    state_next = S_IRD;
                end
                else
                begin
                    wdata = {job_reg.id, job_reg.ping};
                    rcount_next = rcount_reg + RIW'(1);
                    state_next = S_RES;
                end
            end
            // Best scan, remote part. One candidate is held back so the
            // final beat can carry last.
            S_BRD:
            begin
                if (idx_reg >= rcount_reg || n_full)
                begin
                    lidx_next = '0;
                    state_next = S_BLOC;
                end
                else
                begin
                    state_next = S_BCHK;
                end
            end
            S_BCHK:
            begin
                cand = (rd_ent.id != job_reg.id);
                if (!(cand && pv_reg && !can_emit))
                begin
                    if (cand)
                    begin
                        emit_v = pv_reg;
                        e_id = pid_reg;
                        e_found = 1'b1;
                        e_last = 1'b0;
                        pv_next = 1'b1;
                        pid_next = rd_ent.id;
                        n_next = n_reg + NW'(1);
                    end
                    idx_next = idx_reg + RIW'(1);
                    state_next = S_BRD;
                end
            end
            S_BLOC:
            begin
                if (lidx_reg >= lcount_reg || n_full)
                begin
                    state_next = S_BFIN;
                end
                else
                begin
                    cand = (lcand != job_reg.id);
                    if (!(cand && pv_reg && !can_emit))
                    begin
                        if (cand)
                        begin
                            emit_v = pv_reg;
                            e_id = pid_reg;
                            e_found = 1'b1;
                            e_last = 1'b0;
                            pv_next = 1'b1;
                            pid_next = lcand;
                            n_next = n_reg + NW'(1);
                        end
                        lidx_next = lidx_reg + LIW'(1);
                    end
                end
            end
            S_BFIN:
            begin
                if (can_emit)
                begin
                    emit_v = 1'b1;
                    e_id = pv_reg ? pid_reg : '0;
                    e_found = pv_reg;
                    state_next = S_IDLE;
                end
            end
            S_RES:
            begin
                if (can_emit)
                begin
                    emit_v = 1'b1;
                    e_status = st_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rcount_reg <= '0;
            lcount_reg <= '0;
            ov_reg <= 1'b0;
            pv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rcount_reg <= rcount_next;
            lcount_reg <= lcount_next;
            pv_reg <= pv_next;
            if (can_emit)
            begin
                ov_reg <= emit_v;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        idx_reg <= idx_next;
        lidx_reg <= lidx_next;
        lid_reg <= lid_next;
        n_reg <= n_next;
        pid_reg <= pid_next;
        st_reg <= st_next;
        if (can_emit && emit_v)
        begin
            ost_reg <= e_status;
            oid_reg <= e_id;
            ofound_reg <= e_found;
            olast_reg <= e_last;
        end
    end

    assign out_valid = ov_reg;
    assign status = ost_reg;
    assign best_peer_id = oid_reg;
    assign found = ofound_reg;
    assign last = olast_reg;

endmodule

FILE: design/peer_table_best_by_latency.sv
// Peer table: remote peers sorted by ping in a RAM with one write port and
// one registered read port, local peers newest first in flip-flops. A two-beat
// queue takes commands while the sequencer works. A remote add, remove or
// update first searches the remote entries with one registered RAM read each,
// then shifts entries, each move a registered RAM read followed by a write.
// Best visits the remote entries, then the local entries, and stops once
// MAX_BEST peers are gathered. The tables come out of reset empty; no clearing
// pass.
module peer_table_best_by_latency #(
    parameter int MAX_BEST = ptb_pkg::MAX_BEST_DEF,
    parameter int REMOTE_DEPTH = ptb_pkg::REMOTE_DEPTH_DEF,
    parameter int LOCAL_DEPTH = ptb_pkg::LOCAL_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [15:0] peer_id,
    input  logic        is_local,
    input  logic [15:0] ping,
    input  logic [15:0] old_ping,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] best_peer_id,
    output logic        found,
    output logic        last
);
    import ptb_pkg::*;

    logic q_valid;
    logic q_pop;
    job_t q_job;

    ptb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .peer_id  (peer_id),
        .is_local (is_local),
        .ping     (ping),
        .old_ping (old_ping),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .q_pop    (q_pop)
    );

    ptb_back #(
        .MAX_BEST     (MAX_BEST),
        .REMOTE_DEPTH (REMOTE_DEPTH),
        .LOCAL_DEPTH  (LOCAL_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_job        (q_job),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .best_peer_id (best_peer_id),
        .found        (found),
        .last         (last)
    );

endmodule

FILE: design/ptb_checker.sv
module ptb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [15:0] best_peer_id,
    input logic        found,
    input logic        last
);
    import ptb_pkg::*;

    // A beat that carries a peer is always an ok answer to best.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == ST_OK)
        else $error("peer beat with non-ok status");

    // A beat without a peer ends its command and carries id zero.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last && best_peer_id == '0)
        else $error("empty beat not final or nonzero id");

    // After a non-final peer beat is taken, the next offered beat still
    // belongs to the same best answer and carries an ok status.
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && found && !last ##1 out_valid
        |-> status == ST_OK)
        else $error("error beat inside a best sequence");

    // A stalled beat stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(best_peer_id))
        else $error("stalled beat dropped or changed");

endmodule

bind peer_table_best_by_latency ptb_checker u_ptb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .best_peer_id (best_peer_id),
    .found        (found),
    .last         (last)
);
